>>> src/b64d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and codes for the base64 stream decoder
// Holds the classified-symbol record passed from the front end through the
// queue to the back end, and the status codes reported on the output.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Character class produced by the front end
  typedef struct packed {
    logic [5:0] sextet;   // 6-bit value of an alphabet character
    logic       is_pad;   // character is '='
    logic       invalid;  // not in the alphabet and not '='
    logic       last;     // last character of the string
  } sym_class_t;

  // Status codes reported with the last character
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BADCHAR = 2'd1;
  localparam logic [1:0] STATUS_BADPAD  = 2'd2;
  localparam logic [1:0] STATUS_BADLEN  = 2'd3;

  // Positions within a group of four characters
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_FOURTH = 2'd3;

endpackage
`default_nettype wire

>>> src/b64d_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_front: input classifier
// Accepts characters from the input stream while the queue has room and maps
// each one to its 6-bit value, a pad flag or an invalid flag.
// ----------------------------------------------------------------------------
module b64d_front (
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,  // [7:0] symbol
  input  wire logic                  s_axis_tlast,  // final_symbol
  input  wire logic                  queue_ready,
  output logic                       push,
  output b64d_pkg::sym_class_t       push_entry
);
  import b64d_pkg::*;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Take a transaction whenever the queue can hold it
  assign s_axis_tready = queue_ready;
  assign push          = s_axis_tvalid && queue_ready;

  // Classify the character
  always_comb begin
    push_entry         = '0;
    push_entry.last    = s_axis_tlast;
    if (s_axis_tdata inside {[8'h41:8'h5A]}) begin
      push_entry.sextet = 6'(s_axis_tdata - 8'h41);
    end else if (s_axis_tdata inside {[8'h61:8'h7A]}) begin
      push_entry.sextet = 6'(s_axis_tdata - 8'd71);
    end else if (s_axis_tdata inside {[8'h30:8'h39]}) begin
      push_entry.sextet = 6'(s_axis_tdata + 8'd4);
    end else if (s_axis_tdata == 8'h2B) begin
      push_entry.sextet = 6'd62;
    end else if (s_axis_tdata == 8'h2F) begin
      push_entry.sextet = 6'd63;
    end else if (s_axis_tdata == PAD_CHAR) begin
      push_entry.is_pad = 1'b1;
    end else begin
      push_entry.invalid = 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> src/b64d_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_fifo: classified-symbol queue
// Small register queue between the classifier and the decode engine so that
// either side can stall on its own.
// ----------------------------------------------------------------------------
module b64d_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire b64d_pkg::sym_class_t  push_entry,
  output logic                       ready,
  input  wire logic                  pop,
  output logic                       not_empty,
  output b64d_pkg::sym_class_t       head
);
  import b64d_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  sym_class_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign ready     = (count != FULL_CNT);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> src/b64d_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_back: decode engine
// Tracks the position within each group of four, the leftover bits, padding
// and the sticky error, and registers one result per character.
// ----------------------------------------------------------------------------
module b64d_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  not_empty,
  input  wire b64d_pkg::sym_class_t  head,
  output logic                       pop,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [15:0]                m_axis_tdata,  // [7:0] data_byte, [8] byte_valid,
                                                    // [10:9] status, rest zero
  output logic                       m_axis_tlast   // string_done
);
  import b64d_pkg::*;

  logic [1:0] quartet_position;
  logic [5:0] leftover_bits;
  logic       padding_seen;
  logic [1:0] error_code;

  logic [1:0] quartet_position_next;
  logic [5:0] leftover_bits_next;
  logic       padding_seen_next;
  logic [1:0] error_code_next;

  logic [1:0] err;
  logic [7:0] byte_val;
  logic       have_byte;
  logic [1:0] status_val;

  logic [7:0] data_byte;
  logic       byte_valid;
  logic [1:0] status;
  logic       string_done;

  // Pop when the output register is free or being drained
  assign pop = not_empty && (!m_axis_tvalid || m_axis_tready);

  // Decode one character
  always_comb begin
    err                = STATUS_OK;
    byte_val           = '0;
    have_byte          = 1'b0;
    leftover_bits_next = leftover_bits;
    padding_seen_next  = padding_seen;

    if (padding_seen) begin
      if (!(head.is_pad && quartet_position == POS_FOURTH && head.last)) begin
        err = STATUS_BADPAD;
      end
    end else if (head.is_pad) begin
      if (quartet_position == POS_FOURTH) begin
        if (!head.last) begin
          err = STATUS_BADPAD;
        end
      end else if (quartet_position == POS_THIRD) begin
        if (!head.last) begin
          padding_seen_next = 1'b1;
        end
      end else begin
        err = STATUS_BADPAD;
      end
    end else if (head.invalid) begin
      err = STATUS_BADCHAR;
    end else begin
      case (quartet_position)
        POS_FIRST: begin
          leftover_bits_next = head.sextet;
        end
        POS_SECOND: begin
          byte_val           = {leftover_bits, head.sextet[5:4]};
          leftover_bits_next = {2'b00, head.sextet[3:0]};
          have_byte          = 1'b1;
        end
        POS_THIRD: begin
          byte_val           = {leftover_bits[3:0], head.sextet[5:2]};
          leftover_bits_next = {4'b0000, head.sextet[1:0]};
          have_byte          = 1'b1;
        end
        default: begin
          byte_val           = {leftover_bits[1:0], head.sextet};
          leftover_bits_next = '0;
          have_byte          = 1'b1;
        end
      endcase
    end

    // Keep the first error
    error_code_next = (error_code == STATUS_OK) ? err : error_code;

    // Report status on the last character; length error wins
    status_val = STATUS_OK;
    if (head.last) begin
      status_val = (quartet_position != POS_FOURTH) ? STATUS_BADLEN : error_code_next;
    end
    if (error_code_next != STATUS_OK || status_val != STATUS_OK) begin
      have_byte = 1'b0;
    end

    quartet_position_next = quartet_position + 2'd1;

    // Clear everything at the end of a string
    if (head.last) begin
      quartet_position_next = POS_FIRST;
      leftover_bits_next    = '0;
      padding_seen_next     = 1'b0;
      error_code_next       = STATUS_OK;
    end
  end

  // Update decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      quartet_position <= POS_FIRST;
      leftover_bits    <= '0;
      padding_seen     <= 1'b0;
      error_code       <= STATUS_OK;
    end else if (pop) begin
      quartet_position <= quartet_position_next;
      leftover_bits    <= leftover_bits_next;
      padding_seen     <= padding_seen_next;
      error_code       <= error_code_next;
    end
  end

  // Hold the output transaction until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_byte   <= have_byte ? byte_val : 8'h00;
      byte_valid  <= have_byte;
      status      <= status_val;
      string_done <= head.last;
    end
  end

  assign m_axis_tdata = {5'b00000, status, byte_valid, data_byte};
  assign m_axis_tlast = string_done;

endmodule
`default_nettype wire

>>> src/base64_stream_decoder.sv
`default_nettype none
// Each character is stored in the queue, and its result in the output register.
// Throughput: one character per cycle, sustained while the output is drained;
//   the queue and the output register let each side stall on its own.
// Every character gives exactly one output transaction.
// Reset (rst, synchronous): empties the queue, drops a pending result and
//   clears position, leftover bits, padding flag and error.
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming base64 decoder
// Decodes one base64 character per transaction into at most one byte, with
// padding and length checks and a status reported at the end of each string.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] symbol
  input  wire logic        s_axis_tlast,  // final_symbol
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [7:0] data_byte, [8] byte_valid,
                                          // [10:9] status, rest zero
  output logic             m_axis_tlast   // string_done
);
  import b64d_pkg::*;

  logic       queue_ready;
  logic       push;
  sym_class_t push_entry;
  logic       pop;
  logic       not_empty;
  sym_class_t head;

  // Classify incoming characters
  b64d_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .queue_ready   (queue_ready),
    .push          (push),
    .push_entry    (push_entry)
  );

  // Decouple front and back
  b64d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .ready      (queue_ready),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  // Decode and emit results
  b64d_back u_back (
    .clk           (clk),
    .rst           (rst),
    .not_empty     (not_empty),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

>>> tb/base64_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_tb: self-checking bench for the base64 stream decoder
// Feeds base64 strings one character per transaction and predicts each output
// transaction with a behavioral decoder kept in step with the block. Directed
// strings cover the alphabet ends, padding forms and the error statuses.
// Random strings are mostly well-formed, mixed with corrupted, truncated,
// lengthened, badly padded and noise strings. Both sides stall in random bursts.
// ----------------------------------------------------------------------------
module base64_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::*;

  localparam logic [7:0] PAD_CHAR    = 8'h3D;
  localparam logic [6:0] NO_SEXTET   = 7'h40;
  localparam int         CYCLE_LIMIT = 600000;
  localparam int         DRAIN_WAIT  = 8;
  localparam int         MAX_REPORTS = 10;

  typedef logic [7:0] text_t[$];

  // One decoded output transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       done;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] symbol
  logic        s_axis_tlast = 1'b0;    // final_symbol
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] data_byte, [8] byte_valid, [10:9] status
  logic        m_axis_tlast;           // string_done

  // Decoder state mirrored by the bench
  logic [1:0] group_pos;
  logic [5:0] carry_bits;
  logic       pad_open;
  logic [1:0] sticky_fault;

  decoded_t pending_results[$];

  bit sender_idle_en   = 1'b1;
  bit receiver_idle_en = 1'b1;
  int stall_left       = 0;
  int cycle_count      = 0;
  int mismatches       = 0;
  int symbols_sent     = 0;
  int strings_sent     = 0;
  int results_checked  = 0;
  int bytes_decoded    = 0;
  int fault_strings    = 0;

  base64_stream_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  // Count cycles for the watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // Behavioral decoder
  // ---------------------------------------------------------------------------
  function automatic logic [6:0] sextet_value(input logic [7:0] ch);
    if (ch >= 8'h41 && ch <= 8'h5A) return 7'(ch - 8'h41);
    if (ch >= 8'h61 && ch <= 8'h7A) return 7'(ch - 8'h61 + 8'd26);
    if (ch >= 8'h30 && ch <= 8'h39) return 7'(ch - 8'h30 + 8'd52);
    if (ch == 8'h2B) return 7'd62;
    if (ch == 8'h2F) return 7'd63;
    return NO_SEXTET;
  endfunction

  function automatic void clear_decoder_state();
    group_pos    = POS_FIRST;
    carry_bits   = 6'd0;
    pad_open     = 1'b0;
    sticky_fault = STATUS_OK;
  endfunction

  // Work out the output for one accepted character and advance the state
  function automatic decoded_t decode_symbol(input logic [7:0] ch, input logic last);
    decoded_t   res;
    logic [1:0] pos;
    logic [1:0] fault;
    logic [6:0] v;
    logic [7:0] b;
    logic       have;
    pos   = group_pos;
    fault = STATUS_OK;
    b     = 8'h00;
    have  = 1'b0;
    v     = sextet_value(ch);
    if (pad_open) begin
      // only the closing '=' may follow an opening one
      if (!(ch == PAD_CHAR && pos == POS_FOURTH && last)) fault = STATUS_BADPAD;
    end else if (ch == PAD_CHAR) begin
      if (pos == POS_FOURTH) begin
        if (!last) fault = STATUS_BADPAD;
      end else if (pos == POS_THIRD) begin
        if (!last) pad_open = 1'b1;
      end else begin
        fault = STATUS_BADPAD;
      end
    end else if (v == NO_SEXTET) begin
      fault = STATUS_BADCHAR;
    end else begin
      case (pos)
        POS_FIRST: begin
          carry_bits = v[5:0];
        end
        POS_SECOND: begin
          b          = {carry_bits, v[5:4]};
          carry_bits = {2'b00, v[3:0]};
          have       = 1'b1;
        end
        POS_THIRD: begin
          b          = {carry_bits[3:0], v[5:2]};
          carry_bits = {4'b0000, v[1:0]};
          have       = 1'b1;
        end
        default: begin
          b          = {carry_bits[1:0], v[5:0]};
          carry_bits = 6'd0;
          have       = 1'b1;
        end
      endcase
    end

    // keep the first error; length error wins at the end of the string
    if (sticky_fault == STATUS_OK && fault != STATUS_OK) sticky_fault = fault;
    res.status = STATUS_OK;
    if (last) res.status = (pos != POS_FOURTH) ? STATUS_BADLEN : sticky_fault;
    if (sticky_fault != STATUS_OK || res.status != STATUS_OK) have = 1'b0;
    res.data_byte  = have ? b : 8'h00;
    res.byte_valid = have;
    res.done       = last;

    if (last) clear_decoder_state();
    else group_pos = pos + 2'd1;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h61 + 8'(v) - 8'd26;
    if (v < 6'd62) return 8'h30 + 8'(v) - 8'd52;
    if (v == 6'd62) return 8'h2B;
    return 8'h2F;
  endfunction

  // Encode raw bytes into padded base64 text
  function automatic text_t encode_bytes(input text_t raw);
    text_t       text;
    logic [23:0] grp;
    int          i;
    int          left;
    for (i = 0; i < raw.size(); i += 3) begin
      left = raw.size() - i;
      grp  = {raw[i], (left > 1) ? raw[i+1] : 8'h00, (left > 2) ? raw[i+2] : 8'h00};
      text = {text, sextet_char(grp[23:18])};
      text = {text, sextet_char(grp[17:12])};
      text = {text, left > 1 ? sextet_char(grp[11:6]) : PAD_CHAR};
      text = {text, left > 2 ? sextet_char(grp[5:0]) : PAD_CHAR};
    end
    return text;
  endfunction

  // Drive one character; called and returns at a falling edge
  task automatic send_symbol(input logic [7:0] ch, input logic last);
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = ch;
    s_axis_tlast  = last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results = {pending_results, decode_symbol(ch, last)};
    symbols_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input text_t text);
    int i;
    for (i = 0; i < text.size(); i++) begin
      send_symbol(text[i], i == text.size() - 1);
    end
    strings_sent++;
  endtask

  task automatic send_ascii(input string s);
    text_t text;
    int    i;
    for (i = 0; i < s.len(); i++) text = {text, s[i]};
    send_string(text);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls and result checking
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else if (receiver_idle_en && $urandom_range(0, 5) == 0) begin
      m_axis_tready = 1'b0;
      stall_left    = $urandom_range(0, 10);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    decoded_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected output transaction: tdata=%h tlast=%b",
                   m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.byte_valid) bytes_decoded++;
        if (want.done && want.status != STATUS_OK) fault_strings++;
        if (m_axis_tdata[7:0] !== want.data_byte || m_axis_tdata[8] !== want.byte_valid ||
            m_axis_tdata[10:9] !== want.status || m_axis_tdata[15:11] !== 5'd0 ||
            m_axis_tlast !== want.done) begin
          if (mismatches < MAX_REPORTS)
            $display({"mismatch at result %0d: expected byte=%h valid=%b status=%0d ",
                      "last=%b, got byte=%h valid=%b status=%0d last=%b upper=%h"},
                     results_checked, want.data_byte, want.byte_valid, want.status,
                     want.done, m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[10:9],
                     m_axis_tlast, m_axis_tdata[15:11]);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Both ends of every alphabet range, as two full groups
  task automatic test_alphabet_range();
    send_ascii("AZaz09+/");
  endtask

  // Double and single padding closing a string
  task automatic test_padding();
    send_ascii("TQ==");
    send_ascii("TWE=");
  endtask

  task automatic test_error_cases();
    text_t text;
    // invalid 0x00 first, then a misplaced pad: first error is kept
    text = {8'h00, PAD_CHAR, 8'h41, 8'h41};
    send_string(text);
    // pad at the first position
    send_ascii("=AAA");
    // character after an opening pad, with the top code 0xFF
    text = {8'h41, 8'h42, PAD_CHAR, 8'hFF};
    send_string(text);
    // string ends mid-group
    send_ascii("AB");
  endtask

  // Random strings until about target characters have gone in
  task automatic test_random_strings(input int target, input bit idle);
    text_t raw;
    text_t text;
    int    kind;
    int    n;
    int    start;
    start = symbols_sent;
    while (symbols_sent - start < target) begin
      sender_idle_en   = idle && ($urandom_range(0, 4) != 0);
      receiver_idle_en = idle && ($urandom_range(0, 4) != 0);
      kind = $urandom_range(0, 9);
      raw.delete();
      text.delete();
      if (kind <= 7) begin
        n = $urandom_range(1, 9);
        repeat (n) raw = {raw, 8'($urandom_range(0, 255))};
        text = encode_bytes(raw);
        case (kind)
          6: text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
          7: begin
            // break the length by one character either way
            if ($urandom_range(0, 1) == 0) void'(text.pop_back());
            else text = {text, sextet_char(6'($urandom))};
          end
          default: ;
        endcase
      end else if (kind == 8) begin
        n = $urandom_range(1, 9);
        repeat (n) text = {text, ($urandom_range(0, 3) == 0) ? PAD_CHAR
                                                             : sextet_char(6'($urandom))};
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) text = {text, 8'($urandom_range(0, 255))};
      end
      send_string(text);
    end
  endtask

  // Abort a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    clear_decoder_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_alphabet_range();
    test_padding();
    test_error_cases();
    test_random_strings(800, 1'b1);
    test_random_strings(200, 1'b0);

    // Drain the outputs, then watch for strays
    s_axis_tvalid    = 1'b0;
    sender_idle_en   = 1'b0;
    receiver_idle_en = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("summary: %0d characters in %0d strings, %0d results checked",
             symbols_sent, strings_sent, results_checked);
    $display("summary: %0d bytes decoded, %0d strings ended with an error status",
             bytes_decoded, fault_strings);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
